/* sv/lrupr_pkg.sv */
`default_nettype none

package lrupr_pkg;

    localparam int MAX_FRAMES = 16;
    localparam int PAGE_BITS  = 8;
    localparam int STAMP_BITS = 16;
    localparam int FRAME_BITS = $clog2(MAX_FRAMES);
    localparam int NUM_BITS   = $clog2(MAX_FRAMES + 1);
    localparam int CFG_BITS   = 5;
    localparam int COUNT_BITS = 16;
    localparam int SLOT_BITS  = 4;

    typedef logic [PAGE_BITS-1:0]  t_page;
    typedef logic [STAMP_BITS-1:0] t_stamp;
    typedef logic [FRAME_BITS-1:0] t_frame;
    typedef logic [NUM_BITS-1:0]   t_num;
    typedef logic [CFG_BITS-1:0]   t_cfg;
    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [SLOT_BITS-1:0]  t_slot;

    localparam t_cfg   CFG_RESET = t_cfg'(4);
    localparam t_count COUNT_MAX = '1;
    localparam t_stamp STAMP_MAX = '1;

    typedef struct packed {
        t_page page_number;
        logic  restart;
    } t_in;

    typedef struct packed {
        logic   hit;
        t_slot  frame_slot;
        logic   replaced;
        t_page  evicted_page;
        t_count replacement_count;
    } t_out;

    typedef struct packed {
        logic   found;
        t_frame slot;
    } t_match;

    // Clamp the programmed frame count to 1..MAX_FRAMES.
    function automatic t_num active_count(input t_cfg v);
        t_num n;
        if (v == '0) begin
            n = t_num'(1);
        end else if (int'(v) > MAX_FRAMES) begin
            n = t_num'(MAX_FRAMES);
        end else begin
            n = t_num'(v);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

/* sv/lru_page_replacement.sv */
// LRU page replacement over up to 16 frames with last-use stamps.
// Input channel: i_in_valid / o_in_stall carry one reference word (page
// number and restart flag). A word is taken at an edge where valid is high
// and stall is low. Output channel: o_out_valid / i_out_stall carry one
// result word per reference: hit, frame slot, replaced, evicted page and
// the running replacement count.
// Config channel: i_cfg_valid / o_cfg_ready writes frames_in_use; ready is
// always high. Write it only while no reference is in flight.
// A reference taken into the input register is resolved by one pass of
// compare and min-tree logic and lands in the output register, from which
// its result is taken. Throughput: one reference per cycle while the
// receiver does not stall, set by the combinational hit compare and
// 16-way stamp min tree feeding the frame state update.
// Reset (synchronous, active low) clears all frames, stamps, counters and
// both pipeline valid flags, and sets frames_in_use to 4.
// When the receiver stalls, the result word holds; the input register can
// still take one more reference, after which o_in_stall rises.
`default_nettype none

module lru_page_replacement (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  lrupr_pkg::t_in        i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output lrupr_pkg::t_out       o_out_word,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  lrupr_pkg::t_cfg       i_cfg_data
);

    localparam int MF = lrupr_pkg::MAX_FRAMES;

    logic              r_in_valid;
    lrupr_pkg::t_in    r_in;
    logic              r_out_valid;
    lrupr_pkg::t_out   r_out;
    lrupr_pkg::t_page  r_pages  [MF];
    lrupr_pkg::t_stamp r_stamps [MF];
    lrupr_pkg::t_stamp r_ref_idx;
    lrupr_pkg::t_count r_repl;
    lrupr_pkg::t_cfg   r_cfg;

    lrupr_pkg::t_page  n_pages  [MF];
    lrupr_pkg::t_stamp n_stamps [MF];
    lrupr_pkg::t_stamp n_ref_idx;
    lrupr_pkg::t_count n_repl;
    lrupr_pkg::t_out   n_out;

    lrupr_pkg::t_page  e_pages  [MF];
    lrupr_pkg::t_stamp e_stamps [MF];
    lrupr_pkg::t_stamp now;
    lrupr_pkg::t_count base_repl;
    lrupr_pkg::t_num   num_active;
    logic [MF-1:0]     active;
    logic [MF-1:0]     hits;
    lrupr_pkg::t_match match;
    lrupr_pkg::t_frame victim;
    logic              fill;
    logic              process;
    logic              in_accept;

    assign process     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !process;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // Restart: work on a cleared view of the state.
    always_comb begin
        for (int j = 0; j < MF; j++) begin
            e_pages[j]  = r_in.restart ? '0 : r_pages[j];
            e_stamps[j] = r_in.restart ? '0 : r_stamps[j];
            active[j]   = lrupr_pkg::t_num'(j) < num_active;
        end
    end

    assign now        = r_in.restart ? '0 : r_ref_idx;
    assign base_repl  = r_in.restart ? '0 : r_repl;
    assign num_active = lrupr_pkg::active_count(r_cfg);
    assign fill       = now < lrupr_pkg::t_stamp'(num_active);

    lrupr_match u_match (
        .i_pages  (e_pages),
        .i_page   (r_in.page_number),
        .i_active (active),
        .o_hits   (hits),
        .o_match  (match)
    );

    lrupr_victim u_victim (
        .i_stamps (e_stamps),
        .i_active (active),
        .o_victim (victim)
    );

    always_comb begin
        lrupr_pkg::t_frame slot;
        for (int j = 0; j < MF; j++) begin
            n_pages[j]  = e_pages[j];
            n_stamps[j] = e_stamps[j];
        end
        n_ref_idx = (now == lrupr_pkg::STAMP_MAX) ? now : now + 1'b1;
        n_repl    = base_repl;
        n_out     = '0;
        slot      = '0;
        if (fill) begin
            // Cold fill: place straight into the next frame.
            slot           = now[lrupr_pkg::FRAME_BITS-1:0];
            n_pages[slot]  = r_in.page_number;
            n_stamps[slot] = now;
        end else if (match.found) begin
            slot      = match.slot;
            n_out.hit = 1'b1;
            for (int j = 0; j < MF; j++) begin
                if (hits[j]) begin
                    n_stamps[j] = now;
                end
            end
        end else begin
            slot               = victim;
            n_out.replaced     = 1'b1;
            n_out.evicted_page = e_pages[victim];
            n_pages[victim]    = r_in.page_number;
            n_stamps[victim]   = now;
            if (base_repl != lrupr_pkg::COUNT_MAX) begin
                n_repl = base_repl + 1'b1;
            end
        end
        n_out.frame_slot        = lrupr_pkg::t_slot'(slot);
        n_out.replacement_count = n_repl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ref_idx   <= '0;
            r_repl      <= '0;
            r_cfg       <= lrupr_pkg::CFG_RESET;
            for (int j = 0; j < MF; j++) begin
                r_pages[j]  <= '0;
                r_stamps[j] <= '0;
            end
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (process) begin
                r_in_valid <= 1'b0;
            end
            if (process) begin
                r_out_valid <= 1'b1;
                r_ref_idx   <= n_ref_idx;
                r_repl      <= n_repl;
                for (int j = 0; j < MF; j++) begin
                    r_pages[j]  <= n_pages[j];
                    r_stamps[j] <= n_stamps[j];
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    // Payload registers: load without reset.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_word;
        end
        if (process) begin
            r_out <= n_out;
        end
    end

    a_hit_not_replaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_word.hit && o_out_word.replaced))
        else $error("hit and replaced both set");

    a_evicted_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.replaced) |-> (o_out_word.evicted_page == '0))
        else $error("evicted page nonzero without replacement");

    a_ref_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        process |=> (r_ref_idx != '0))
        else $error("reference index did not advance");

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        process |=> (r_out.replacement_count == r_repl))
        else $error("reported count differs from counter");

endmodule

`default_nettype wire

/* sv/lrupr_match.sv */
`default_nettype none

module lrupr_match (
    input  lrupr_pkg::t_page  i_pages [lrupr_pkg::MAX_FRAMES],
    input  lrupr_pkg::t_page  i_page,
    input  logic [lrupr_pkg::MAX_FRAMES-1:0] i_active,
    output logic [lrupr_pkg::MAX_FRAMES-1:0] o_hits,
    output lrupr_pkg::t_match o_match
);

    always_comb begin
        for (int j = 0; j < lrupr_pkg::MAX_FRAMES; j++) begin
            o_hits[j] = i_active[j] && (i_pages[j] == i_page);
        end
    end

    // Lowest matching frame wins: scan from the top down.
    always_comb begin
        o_match.found = |o_hits;
        o_match.slot  = '0;
        for (int j = lrupr_pkg::MAX_FRAMES - 1; j >= 0; j--) begin
            if (o_hits[j]) begin
                o_match.slot = lrupr_pkg::t_frame'(j);
            end
        end
    end

endmodule

`default_nettype wire

/* sv/lrupr_victim.sv */
`default_nettype none

module lrupr_victim (
    input  lrupr_pkg::t_stamp i_stamps [lrupr_pkg::MAX_FRAMES],
    input  logic [lrupr_pkg::MAX_FRAMES-1:0] i_active,
    output lrupr_pkg::t_frame o_victim
);

    localparam int LEAVES = 1 << $clog2(lrupr_pkg::MAX_FRAMES);

    typedef logic [lrupr_pkg::STAMP_BITS:0] t_key;

    t_key              key [1:2*LEAVES-1];
    lrupr_pkg::t_frame idx [1:2*LEAVES-1];

    // Leaves in order frame 1, frame 0, frame 2, ... so that the leftmost
    // minimum gives frame 1 the tie against frame 0. Inactive frames carry
    // a set top bit and never win against an active one.
    always_comb begin
        int f;
        for (int p = 0; p < LEAVES; p++) begin
            f = (p == 0) ? 1 : ((p == 1) ? 0 : p);
            if (f < lrupr_pkg::MAX_FRAMES) begin
                key[LEAVES + p] = {~i_active[f], i_stamps[f]};
                idx[LEAVES + p] = lrupr_pkg::t_frame'(f);
            end else begin
                key[LEAVES + p] = '1;
                idx[LEAVES + p] = '0;
            end
        end
        for (int i = LEAVES - 1; i >= 1; i--) begin
            if (key[2*i + 1] < key[2*i]) begin
                key[i] = key[2*i + 1];
                idx[i] = idx[2*i + 1];
            end else begin
                key[i] = key[2*i];
                idx[i] = idx[2*i];
            end
        end
    end

    assign o_victim = idx[1];

endmodule

`default_nettype wire
